// ----- rtl/core/mgs_pkg.sv -----
// mgs_pkg: shared types and constants of the mixed gradient selector
// used by mgs_window, mgs_grad_select and mixed_gradient_select
// no dependencies
package mgs_pkg;

    // field widths fixed by the stream format
    localparam int SAMPLE_W       = 8;
    localparam int GRAD_W         = 9;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int NUM_SLOTS      = 3;

    // default sizing of the line store and row counter
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration reset values
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd768;

    // register index taken from the word address
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // one pixel: foreground and background samples
    typedef struct packed {
        logic [SAMPLE_W-1:0] fg;
        logic [SAMPLE_W-1:0] bg;
    } t_pix;

    // one line store word: the row two above and the row above
    typedef struct packed {
        t_pix older;
        t_pix prior;
    } t_col;

    // gradient pairs of both images for one pending result
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx_f;
        logic signed [GRAD_W-1:0] gy_f;
        logic signed [GRAD_W-1:0] gx_b;
        logic signed [GRAD_W-1:0] gy_b;
        logic                     eof;
    } t_slot;

    // all results caused by one input transfer, in raster order from slot 0
    typedef struct packed {
        t_slot [NUM_SLOTS-1:0]  slot;
        logic  [NUM_SLOTS-1:0]  vld;
    } t_item;

endpackage

// ----- rtl/core/mgs_window.sv -----
// mgs_window: raster position counters, line store memory and the 3x3 window
// forms the gradient pairs of up to three results for each input transfer
// depends on mgs_pkg
module mgs_window #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10,
    parameter int ROW_W     = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [COL_W-1:0]               i_last_col,
    input  logic [ROW_W-1:0]               i_last_row,
    input  logic                           i_restart,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mgs_pkg::SAMPLE_W-1:0]   i_fore_sample,
    input  logic [mgs_pkg::SAMPLE_W-1:0]   i_back_sample,
    input  logic                           i_full,
    output logic                           o_push,
    output mgs_pkg::t_item                 o_item
);
    import mgs_pkg::*;

    // line store: one word per column holds both rows above
    t_col             r_mem [MAX_WIDTH];
    t_col             r_rdata;

    // position of the next transfer
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // current row tail, window words and copies of the first two columns
    t_pix             r_tail0;
    t_pix             r_tail1;
    t_col             r_win_l;
    t_col             r_win_c;
    t_col             r_head0;
    t_col             r_head1;

    // row end write deferred to the next cycle
    logic             r_pw_vld;
    logic [COL_W-1:0] r_pw_addr;
    t_col             r_pw_data;

    logic             accept;
    t_pix             cur;
    logic             first_col;
    logic             last_col;
    logic             last_row;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge2;
    t_col             center;
    t_col             right;
    t_col             imm_data;
    t_col             pend_data;
    logic             we;
    logic [COL_W-1:0] waddr;
    t_col             wdata;
    logic [COL_W-1:0] raddr;

    // gradient pairs of one pixel from its four neighbours
    function automatic t_slot make_slot(input t_pix l, input t_pix r, input t_pix a,
                                        input t_pix b, input logic eof);
        t_slot s;
        s.gx_f = $signed({1'b0, r.fg}) - $signed({1'b0, l.fg});
        s.gy_f = $signed({1'b0, b.fg}) - $signed({1'b0, a.fg});
        s.gx_b = $signed({1'b0, r.bg}) - $signed({1'b0, l.bg});
        s.gy_b = $signed({1'b0, b.bg}) - $signed({1'b0, a.bg});
        s.eof  = eof;
        return s;
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign cur     = {i_fore_sample, i_back_sample};

    // position decode
    assign first_col = (r_col == '0);
    assign last_col  = (r_col == i_last_col);
    assign last_row  = (r_row == i_last_row);
    assign row_ge1   = (r_row != '0);
    assign row_ge2   = (r_row > ROW_W'(1));
    assign col_ge2   = (r_col > COL_W'(1));

    // window operands; a new row starts from the stored first two columns
    assign center = first_col ? r_head0 : r_win_c;
    assign right  = first_col ? r_head1 : r_rdata;

    // slot 0: pixel above, slot 1: left neighbour on the last row, slot 2: frame end
    always_comb begin
        t_pix l0;
        t_pix r0;
        t_pix a0;
        t_pix l1;
        t_pix a1;
        t_pix l2;
        t_pix a2;
        l0 = first_col ? center.prior : r_win_l.prior;
        r0 = last_col ? center.prior : right.prior;
        a0 = row_ge2 ? center.older : center.prior;
        l1 = col_ge2 ? r_tail1 : r_tail0;
        a1 = row_ge1 ? r_win_l.prior : r_tail0;
        l2 = first_col ? cur : r_tail0;
        a2 = row_ge1 ? center.prior : cur;
        o_item.slot[0] = make_slot(l0, r0, a0, cur, 1'b0);
        o_item.slot[1] = make_slot(l1, cur, a1, r_tail0, 1'b0);
        o_item.slot[2] = make_slot(l2, cur, a2, cur, 1'b1);
        o_item.vld[0]  = row_ge1;
        o_item.vld[1]  = last_row && !first_col;
        o_item.vld[2]  = last_row && last_col;
    end

    assign o_push = accept && (o_item.vld != '0);

    // write-back words: one column late, and the row end column
    assign imm_data  = '{older: r_win_l.prior, prior: r_tail0};
    assign pend_data = '{older: center.prior, prior: cur};

    // single memory port pair; the deferred write never meets an immediate one
    assign we    = r_pw_vld || (accept && !first_col);
    assign waddr = r_pw_vld ? r_pw_addr : r_col - COL_W'(1);
    assign wdata = r_pw_vld ? r_pw_data : imm_data;
    assign raddr = r_col + COL_W'(2);

    // line store with write-first read data
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (accept) begin
            r_rdata <= (we && waddr == raddr) ? wdata : r_mem[raddr];
        end
    end

    // position counters and deferred write flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_pw_vld <= 1'b0;
        end else begin
            r_pw_vld <= accept && last_col;
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // window shift, row tail and first column copies
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win_l   <= center;
            r_win_c   <= right;
            r_tail1   <= r_tail0;
            r_tail0   <= cur;
            r_pw_addr <= r_col;
            r_pw_data <= pend_data;
            if (r_col == COL_W'(1)) begin
                r_head0 <= imm_data;
            end
            if (r_col == COL_W'(2)) begin
                r_head1 <= imm_data;
            end
            if (last_col && first_col) begin
                r_head0 <= pend_data;
            end
            if (last_col && r_col == COL_W'(1)) begin
                r_head1 <= pend_data;
            end
        end
    end

endmodule

// ----- rtl/core/mgs_grad_select.sv -----
// mgs_grad_select: hands out the pending results of one transfer one at a time,
// compares squared magnitudes and holds the chosen pair in the output register
// depends on mgs_pkg
module mgs_grad_select (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  mgs_pkg::t_item                      i_item,
    output logic                                o_full,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mgs_pkg::GRAD_W-1:0]   o_grad_x,
    output logic signed [mgs_pkg::GRAD_W-1:0]   o_grad_y,
    output logic                                o_from_back,
    output logic                                o_end_of_frame,
    output logic                                o_last_of_run
);
    import mgs_pkg::*;

    // results of the transfer still to go
    logic [NUM_SLOTS-1:0]       r_pend;
    t_slot [NUM_SLOTS-1:0]      r_slots;

    // compare stage
    logic                       r_c_vld;
    t_slot                      r_c;
    logic                       r_c_last;

    // output register
    logic                       r_o_vld;
    logic signed [GRAD_W-1:0]   r_o_gx;
    logic signed [GRAD_W-1:0]   r_o_gy;
    logic                       r_o_back;
    logic                       r_o_eof;
    logic                       r_o_last;

    logic                       o_load;
    logic                       c_load;
    logic [NUM_SLOTS-1:0]       pick;
    logic [NUM_SLOTS-1:0]       remaining;
    t_slot                      sel_slot;
    logic                       pop;
    logic signed [2*GRAD_W-1:0] p_xf;
    logic signed [2*GRAD_W-1:0] p_yf;
    logic signed [2*GRAD_W-1:0] p_xb;
    logic signed [2*GRAD_W-1:0] p_yb;
    logic [2*SAMPLE_W:0]        mag_f;
    logic [2*SAMPLE_W:0]        mag_b;
    logic                       fore;

    // stage enables
    assign o_load = !r_o_vld || !i_stall;
    assign c_load = !r_c_vld || o_load;

    // lowest pending slot first keeps raster order
    assign pick      = r_pend & (~r_pend + NUM_SLOTS'(1));
    assign remaining = r_pend & ~pick;
    assign sel_slot  = pick[0] ? r_slots[0] : (pick[1] ? r_slots[1] : r_slots[2]);
    assign pop       = c_load && (r_pend != '0);
    assign o_full    = !((r_pend == '0) || (c_load && remaining == '0));

    // squared magnitudes; each square is below 2**16
    assign p_xf  = r_c.gx_f * r_c.gx_f;
    assign p_yf  = r_c.gy_f * r_c.gy_f;
    assign p_xb  = r_c.gx_b * r_c.gx_b;
    assign p_yb  = r_c.gy_b * r_c.gy_b;
    assign mag_f = {1'b0, p_xf[2*SAMPLE_W-1:0]} + {1'b0, p_yf[2*SAMPLE_W-1:0]};
    assign mag_b = {1'b0, p_xb[2*SAMPLE_W-1:0]} + {1'b0, p_yb[2*SAMPLE_W-1:0]};
    assign fore  = mag_f > mag_b;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_push) begin
                r_pend <= i_item.vld;
            end else if (pop) begin
                r_pend <= remaining;
            end
            if (c_load) begin
                r_c_vld <= (r_pend != '0);
            end
            if (o_load) begin
                r_o_vld <= r_c_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots <= i_item.slot;
        end
        if (pop) begin
            r_c      <= sel_slot;
            r_c_last <= (remaining == '0);
        end
        if (o_load) begin
            r_o_gx   <= fore ? r_c.gx_f : r_c.gx_b;
            r_o_gy   <= fore ? r_c.gy_f : r_c.gy_b;
            r_o_back <= !fore;
            r_o_eof  <= r_c.eof;
            r_o_last <= r_c_last;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_grad_x       = r_o_gx;
    assign o_grad_y       = r_o_gy;
    assign o_from_back    = r_o_back;
    assign o_end_of_frame = r_o_eof;
    assign o_last_of_run  = r_o_last;

endmodule

// ----- rtl/core/mixed_gradient_select.sv -----
// mixed_gradient_select: streaming mixed-gradient selector for one channel plane
// path: a result passes the pending slots, the compare stage and the output register
// throughput: one input transfer per cycle while the result stream is not stalled; on the last row
//   the output port carries one result per cycle, so a transfer there waits for the previous one's last result
// line store: one read and one write port, a row end write is deferred to the next cycle
// reset: counters and handshake flags clear, line store contents are undefined, no clear pass
module mixed_gradient_select #(
    parameter int MAX_WIDTH  = mgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // input stream
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [mgs_pkg::SAMPLE_W-1:0]            i_fore_sample,
    input  logic [mgs_pkg::SAMPLE_W-1:0]            i_back_sample,
    // result stream
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [mgs_pkg::GRAD_W-1:0]       o_grad_x,
    output logic signed [mgs_pkg::GRAD_W-1:0]       o_grad_y,
    output logic                                    o_from_back,
    output logic                                    o_end_of_frame,
    output logic                                    o_last_of_run
);
    import mgs_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic                      cfg_wr;
    logic [COL_W-1:0]          last_col;
    logic [ROW_W-1:0]          last_row;
    logic                      sel_full;
    logic                      push;
    t_item                     item;

    // configuration registers, a write restarts the frame
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // effective frame size: zero acts as one, large values saturate
    always_comb begin
        if (r_frame_width == '0) begin
            last_col = '0;
        end else if (32'(r_frame_width) >= MAX_WIDTH) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(r_frame_width - 1'b1);
        end
        if (r_frame_height == '0) begin
            last_row = '0;
        end else if (32'(r_frame_height) >= MAX_HEIGHT) begin
            last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            last_row = ROW_W'(r_frame_height - 1'b1);
        end
    end

    // line store and window
    mgs_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .ROW_W     (ROW_W)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_last_col    (last_col),
        .i_last_row    (last_row),
        .i_restart     (cfg_wr),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_fore_sample (i_fore_sample),
        .i_back_sample (i_back_sample),
        .i_full        (sel_full),
        .o_push        (push),
        .o_item        (item)
    );

    // result sequencing and selection
    mgs_grad_select u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (item),
        .o_full         (sel_full),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_from_back    (o_from_back),
        .o_end_of_frame (o_end_of_frame),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- bench/mixed_gradient_select_tb.sv -----
// testbench for mixed_gradient_select: random and directed pixel streams, APB setup
// checks every result against a built-in line-store predictor of the gradient selector
// depends on mgs_pkg and the mixed_gradient_select rtl
module mixed_gradient_select_tb;
    import mgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    // one expected result
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     from_back;
        logic                     eof;
        logic                     last;
    } t_grad_res;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     psel           = 1'b0;
    logic                     penable        = 1'b0;
    logic                     pwrite         = 1'b0;
    logic [2:0]               paddr          = '0;
    logic [31:0]              pwdata         = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic [SAMPLE_W-1:0]      i_fore_sample  = '0;
    logic [SAMPLE_W-1:0]      i_back_sample  = '0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic signed [GRAD_W-1:0] o_grad_x;
    logic signed [GRAD_W-1:0] o_grad_y;
    logic                     o_from_back;
    logic                     o_end_of_frame;
    logic                     o_last_of_run;

    mixed_gradient_select dut (.*);

    // pixels waiting to be sent and gradients waiting to arrive
    t_pix      pixel_q[$];
    t_grad_res grad_q[$];

    int errors      = 0;
    int cycle_count = 0;
    int send_pct    = 0;
    int recv_pct    = 0;
    bit in_taken    = 1'b0;

    // predictor state
    t_pix                      older_rows [DEF_MAX_WIDTH];
    t_pix                      prior_rows [DEF_MAX_WIDTH];
    t_pix                      tail0, tail1;
    int unsigned               col_pos, row_pos;
    logic [FRAME_WIDTH_W-1:0]  width_cfg  = FRAME_WIDTH_RST;
    logic [FRAME_HEIGHT_W-1:0] height_cfg = FRAME_HEIGHT_RST;

    initial begin
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            older_rows[i] = '0;
            prior_rows[i] = '0;
        end
        tail0   = '0;
        tail1   = '0;
        col_pos = 0;
        row_pos = 0;
    end

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // larger squared magnitude wins, a tie goes to the background
    function automatic t_grad_res pick_grad(t_pix lf, t_pix rt, t_pix ab, t_pix bl, logic eof);
        t_grad_res g;
        int        gxf, gyf, gxb, gyb;
        gxf = int'(rt.fg) - int'(lf.fg);
        gyf = int'(bl.fg) - int'(ab.fg);
        gxb = int'(rt.bg) - int'(lf.bg);
        gyb = int'(bl.bg) - int'(ab.bg);
        if (gxf * gxf + gyf * gyf > gxb * gxb + gyb * gyb) begin
            g.gx        = gxf[GRAD_W-1:0];
            g.gy        = gyf[GRAD_W-1:0];
            g.from_back = 1'b0;
        end else begin
            g.gx        = gxb[GRAD_W-1:0];
            g.gy        = gyb[GRAD_W-1:0];
            g.from_back = 1'b1;
        end
        g.eof  = eof;
        g.last = 1'b0;
        return g;
    endfunction

    // advance the predictor by one pixel and queue the gradients it causes
    task automatic select_gradients(logic [SAMPLE_W-1:0] fs, logic [SAMPLE_W-1:0] bs);
        t_grad_res   res [3];
        int          n;
        int unsigned w, h, c, r;
        t_pix        cur, above, left, right, self;
        w = eff_dim(width_cfg, DEF_MAX_WIDTH);
        h = eff_dim(height_cfg, DEF_MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        cur.fg = fs;
        cur.bg = bs;
        n = 0;
        if (c >= w)
            c = w - 1;
        if (r >= h)
            r = h - 1;

        // pixel directly above
        if (r >= 1) begin
            above  = (r >= 2) ? older_rows[c] : prior_rows[c];
            left   = (c >= 1) ? prior_rows[c-1] : prior_rows[c];
            right  = (c + 1 < w) ? prior_rows[c+1] : prior_rows[c];
            res[n] = pick_grad(left, right, above, cur, 1'b0);
            n++;
        end
        // last row: left neighbour, then the final pixel itself
        if (r == h - 1) begin
            if (c >= 1) begin
                self   = tail0;
                left   = (c >= 2) ? tail1 : self;
                above  = (r >= 1) ? prior_rows[c-1] : self;
                res[n] = pick_grad(left, cur, above, self, 1'b0);
                n++;
            end
            if (c == w - 1) begin
                left   = (c >= 1) ? tail0 : cur;
                above  = (r >= 1) ? prior_rows[c] : cur;
                res[n] = pick_grad(left, cur, above, cur, 1'b1);
                n++;
            end
        end

        // line stores take the previous column, the row end flushes
        if (c >= 1) begin
            older_rows[c-1] = prior_rows[c-1];
            prior_rows[c-1] = tail0;
        end
        if (c == w - 1) begin
            older_rows[c] = prior_rows[c];
            prior_rows[c] = cur;
        end
        tail1 = tail0;
        tail0 = cur;

        if (c == w - 1) begin
            col_pos = 0;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end

        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            grad_q.push_back(res[i]);
        end
    endtask

    // record input transfers
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            select_gradients(i_fore_sample, i_back_sample);
            in_taken = 1'b1;
        end
    end

    // input driver, holds the payload until the transfer
    always @(negedge i_clk) begin : feed
        t_pix nxt;
        logic nv;
        nv = i_in_valid;
        if (!i_in_valid || in_taken) begin
            nv = 1'b0;
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_pct) begin
                nxt = pixel_q.pop_front();
                nv  = 1'b1;
                i_fore_sample <= nxt.fg;
                i_back_sample <= nxt.bg;
            end
        end
        in_taken = 1'b0;
        i_in_valid <= nv;
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_pct);
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin : watch
        t_grad_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grad_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual gx %0d gy %0d back %0b",
                         $time, o_grad_x, o_grad_y, o_from_back);
            end else begin
                want = grad_q.pop_front();
                check_field("grad_x", int'(want.gx), int'(o_grad_x));
                check_field("grad_y", int'(want.gy), int'(o_grad_y));
                check_field("from_back", int'(want.from_back), int'(o_from_back));
                check_field("end_of_frame", int'(want.eof), int'(o_end_of_frame));
                check_field("last_of_run", int'(want.last), int'(o_last_of_run));
            end
        end
    end

    // wait for the pipe to empty, then let the block settle
    task automatic drain(int settle);
        while (pixel_q.size() != 0 || i_in_valid || grad_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic cfg_write(t_reg_idx idx, logic [31:0] val);
        logic [31:0] stored;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_FRAME_WIDTH) begin
            width_cfg = val[FRAME_WIDTH_W-1:0];
            stored    = 32'(width_cfg);
        end else begin
            height_cfg = val[FRAME_HEIGHT_W-1:0];
            stored     = 32'(height_cfg);
        end
        col_pos = 0;
        row_pos = 0;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_FRAME_WIDTH)
            check_field("frame_width readback", int'(stored),
                        int'(prdata[FRAME_WIDTH_W-1:0]));
        else
            check_field("frame_height readback", int'(stored),
                        int'(prdata[FRAME_HEIGHT_W-1:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(logic [31:0] w, logic [31:0] h);
        drain(SETTLE);
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
    endtask

    task automatic push_pixel(logic [SAMPLE_W-1:0] f, logic [SAMPLE_W-1:0] b);
        pixel_q.push_back(t_pix'({f, b}));
    endtask

    // random content: plain, fore equal to back, or only extremes
    task automatic push_frame(int count, int style);
        logic [SAMPLE_W-1:0] f, b;
        for (int i = 0; i < count; i++) begin
            f = SAMPLE_W'($urandom_range(255));
            b = SAMPLE_W'($urandom_range(255));
            if (style == 1)
                b = f;
            else if (style == 2) begin
                f = $urandom_range(1) ? 8'd255 : 8'd0;
                b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            push_pixel(f, b);
        end
    endtask

    // whole frames of small random sizes, some cut short by a new setup
    task automatic run_random(int sp, int rp, int target, bit pause_once);
        int          done, cnt, half, style;
        int unsigned w, h;
        bit          cut;
        logic [31:0] wv, hv;
        send_pct = sp;
        recv_pct = rp;
        done     = 0;
        cut      = 1'b1;
        while (done < target) begin
            if (cut || $urandom_range(1)) begin
                case ($urandom_range(9))
                    0:       wv = 0;
                    1:       wv = 1;
                    9:       wv = $urandom_range(9, 20);
                    default: wv = $urandom_range(2, 8);
                endcase
                hv = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
                set_frame(wv, hv);
            end
            w     = eff_dim(width_cfg, DEF_MAX_WIDTH);
            h     = eff_dim(height_cfg, DEF_MAX_HEIGHT);
            cnt   = w * h;
            style = $urandom_range(3);
            cut   = ($urandom_range(4) == 0) && (cnt > 1);
            if (cut)
                cnt = $urandom_range(1, cnt - 1);
            // the phase ends at its pixel budget, the next setup restarts the frame
            if (cnt > target - done)
                cnt = target - done;
            if (pause_once && cnt >= 4) begin
                // hold the sender mid-frame until every result is out
                half = cnt / 2;
                push_frame(half, style);
                drain(0);
                push_frame(cnt - half, style);
                pause_once = 1'b0;
            end else begin
                push_frame(cnt, style);
            end
            done += cnt;
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a few row-zero pixels at the reset setup, no results due
        push_frame(5, 0);

        // 3x3 checker in the foreground over a flat background
        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            push_pixel((i % 2) ? 8'd255 : 8'd0, 8'd128);
        // single row, height zero acts as one, background wins
        set_frame(4, 0);
        for (int i = 0; i < 4; i++)
            push_pixel(8'd7, (i % 2) ? 8'd255 : 8'd0);
        // single column
        set_frame(1, 3);
        for (int i = 0; i < 3; i++)
            push_pixel((i == 1) ? 8'd0 : 8'd255, 8'd0);
        // single pixel, width zero acts as one
        set_frame(0, 1);
        push_pixel(8'd255, 8'd0);
        // equal images tie, background wins
        set_frame(2, 2);
        for (int i = 0; i < 4; i++)
            push_pixel((i == 1 || i == 2) ? 8'd255 : 8'd0,
                       (i == 1 || i == 2) ? 8'd255 : 8'd0);

        // widest row setting on a single row, width saturates, cut short
        set_frame(32'd2047, 32'd1);
        push_frame(24, 0);
        // tallest frame one pixel wide, height saturates, cut short
        set_frame(32'd0, 32'd8191);
        push_frame(16, 0);

        // random frames under each idling pattern
        run_random(0, 0, 28, 1'b0);
        run_random(79, 0, 28, 1'b0);
        run_random(0, 79, 28, 1'b1);
        run_random(28, 28, 28, 1'b0);

        drain(10);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
